// ----- design/voxel_vertex_pack_dedup_unit_macros.svh -----
// assertion helpers for the vertex dedup unit
`ifndef VOXEL_VERTEX_PACK_DEDUP_UNIT_MACROS_SVH
`define VOXEL_VERTEX_PACK_DEDUP_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define VVPD_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define VVPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/vvpd_pkg.sv -----
package vvpd_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned WORD_W = 43;

    localparam logic [2:0] CODE_XNEG = 3'd0;
    localparam logic [2:0] CODE_XPOS = 3'd1;
    localparam logic [2:0] CODE_YNEG = 3'd2;
    localparam logic [2:0] CODE_YPOS = 3'd3;
    localparam logic [2:0] CODE_ZNEG = 3'd4;
    localparam logic [2:0] CODE_ZPOS = 3'd5;

    typedef struct packed {
        logic              err;
        logic              neg;
        logic [7:0]        mag;
        logic signed [8:0] sp;
    } pos_t;

    typedef struct packed {
        logic              err;
        logic [WORD_W-1:0] word;
        logic signed [8:0] sp_x;
        logic signed [8:0] sp_y;
        logic signed [8:0] sp_z;
    } front_t;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [WORD_W-1:0] key;
    } tok_t;

    // scale q.4 by 10, truncate toward zero
    function automatic pos_t scale_pos(input logic [15:0] p);
        logic [16:0] mag;
        logic [19:0] prod;
        logic [15:0] q;
        pos_t        r;
        mag    = p[15] ? (17'd0 - {p[15], p}) : {1'b0, p};
        prod   = {mag, 3'b000} + {2'b00, mag, 1'b0};
        q      = prod[19:4];
        r.err  = q > 16'd255;
        r.neg  = p[15] && (q != 16'd0);
        r.mag  = q[7:0];
        r.sp   = r.neg ? $signed(9'd0 - {1'b0, q[7:0]}) : $signed({1'b0, q[7:0]});
        return r;
    endfunction

endpackage

// ----- design/voxel_vertex_pack_dedup_unit.sv -----
// an accepted word is registered in the front stage, then launched as a lookup token
//   that walks the cell chain one cell per cycle; a word that the front stage rejects
//   skips the lookup. A new word is taken only once the result of the last one has been
//   registered; a stalled result holds the input
// reset: count zero, bounding box 255 / -255, table contents undefined until written
module voxel_vertex_pack_dedup_unit
#(
    parameter int unsigned TABLE_DEPTH = vvpd_pkg::DEF_TABLE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u
    input  logic [103:0]  s_tdata,
    // first
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // vert_idx, vertex_word, box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z
    output logic [111:0]  m_tdata,
    // is_new, error
    output logic [1:0]    m_tuser
);
    `include "voxel_vertex_pack_dedup_unit_macros.svh"
    import vvpd_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LAUNCH = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic signed [8:0] BOX_HI = 9'sd255;
    localparam logic signed [8:0] BOX_LO = -9'sd255;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CW-1:0]     count_reg;
    logic              found_reg;
    logic [IW-1:0]     fidx_reg;
    logic signed [8:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [8:0] max_x_reg, max_y_reg, max_z_reg;
    logic signed [8:0] min_x_next, min_y_next, min_z_next;
    logic signed [8:0] max_x_next, max_y_next, max_z_next;
    logic              m_tvalid_reg;
    logic [111:0]      m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    logic              in_fire;
    logic              fin_fire;
    logic              full;
    logic              err_f;
    logic              is_new;
    logic [IW-1:0]     res_idx;
    logic              wr_en;
    front_t            front;

    tok_t              tok_chain [TABLE_DEPTH+1];
    logic [IW-1:0]     idx_chain [TABLE_DEPTH+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign fin_fire = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    vvpd_front u_front
    (
        .clk    (clk),
        .ld     (in_fire),
        .pos_x  (s_tdata[15:0]),
        .pos_y  (s_tdata[31:16]),
        .pos_z  (s_tdata[47:32]),
        .norm_x (s_tdata[58:48]),
        .norm_y (s_tdata[69:59]),
        .norm_z (s_tdata[80:70]),
        .tex_u  (s_tdata[97:81]),
        .res    (front)
    );

    assign tok_chain[0] = {((state_reg == ST_LAUNCH) && !front.err), 1'b0, front.word};
    assign idx_chain[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        vvpd_cell
        #(
            .DEPTH (TABLE_DEPTH),
            .IDX   (g)
        )
        u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[g]),
            .idx_in  (idx_chain[g]),
            .tok_out (tok_chain[g+1]),
            .idx_out (idx_chain[g+1]),
            .count   (count_reg),
            .wr_en   (wr_en),
            .wr_addr (count_reg[IW-1:0]),
            .wr_word (front.word)
        );
    end

    always_comb
    begin
        full    = (count_reg >= CW'(TABLE_DEPTH));
        err_f   = front.err || (!found_reg && full);
        is_new  = !err_f && !found_reg;
        res_idx = found_reg ? fidx_reg : count_reg[IW-1:0];
        wr_en   = fin_fire && is_new;

        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        min_z_next = min_z_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        max_z_next = max_z_reg;
        if (!err_f)
        begin
            if (front.sp_x < min_x_reg) min_x_next = front.sp_x;
            if (front.sp_y < min_y_reg) min_y_next = front.sp_y;
            if (front.sp_z < min_z_reg) min_z_next = front.sp_z;
            if (front.sp_x > max_x_reg) max_x_next = front.sp_x;
            if (front.sp_y > max_y_reg) max_y_next = front.sp_y;
            if (front.sp_z > max_z_reg) max_z_next = front.sp_z;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = front.err ? ST_FINISH : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (tok_chain[TABLE_DEPTH].valid) state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (fin_fire) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            fidx_reg     <= '0;
            min_x_reg    <= BOX_HI;
            min_y_reg    <= BOX_HI;
            min_z_reg    <= BOX_HI;
            max_x_reg    <= BOX_LO;
            max_y_reg    <= BOX_LO;
            max_z_reg    <= BOX_LO;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && s_tuser[0])
            begin
                count_reg <= '0;
                min_x_reg <= BOX_HI;
                min_y_reg <= BOX_HI;
                min_z_reg <= BOX_HI;
                max_x_reg <= BOX_LO;
                max_y_reg <= BOX_LO;
                max_z_reg <= BOX_LO;
            end
            if (state_reg == ST_LAUNCH)
            begin
                found_reg <= 1'b0;
            end
            if ((state_reg == ST_SEARCH) && tok_chain[TABLE_DEPTH].valid)
            begin
                found_reg <= tok_chain[TABLE_DEPTH].found;
                fidx_reg  <= idx_chain[TABLE_DEPTH];
            end
            if (fin_fire)
            begin
                min_x_reg <= min_x_next;
                min_y_reg <= min_y_next;
                min_z_reg <= min_z_next;
                max_x_reg <= max_x_next;
                max_y_reg <= max_y_next;
                max_z_reg <= max_z_next;
                if (is_new) count_reg <= count_reg + 1'b1;
            end
            if (fin_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            m_tdata_reg <= {5'd0, max_z_next, max_y_next, max_x_next,
                            min_z_next, min_y_next, min_x_next,
                            err_f ? 43'd0 : front.word,
                            err_f ? 10'd0 : 10'(res_idx)};
            m_tuser_reg <= {err_f, is_new};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `VVPD_ASSERT_HOLD(a_count_bound, count_reg <= CW'(TABLE_DEPTH), "vertex count past depth")
    `VVPD_ASSERT_HOLD(a_tok_in_search, !tok_chain[TABLE_DEPTH].valid || state_reg == ST_SEARCH, "lookup token out of search")
    `VVPD_ASSERT_NEXT(a_count_step, wr_en, count_reg == CW'($past(count_reg) + 1'b1), "count did not advance on store")

endmodule

// ----- design/vvpd_front.sv -----
module vvpd_front
(
    input  logic                  clk,
    input  logic                  ld,
    input  logic [15:0]           pos_x,
    input  logic [15:0]           pos_y,
    input  logic [15:0]           pos_z,
    input  logic [10:0]           norm_x,
    input  logic [10:0]           norm_y,
    input  logic [10:0]           norm_z,
    input  logic [16:0]           tex_u,
    output vvpd_pkg::front_t      res
);
    import vvpd_pkg::*;

    pos_t        px;
    pos_t        py;
    pos_t        pz;
    logic        n_err;
    logic        have_code;
    logic [2:0]  code;
    logic [24:0] tex_prod;
    logic [7:0]  texq;
    front_t      res_next;
    front_t      res_reg;

    always_comb
    begin
        px = scale_pos(pos_x);
        py = scale_pos(pos_y);
        pz = scale_pos(pos_z);

        n_err = ($signed(norm_x) > 11'sd512) || ($signed(norm_x) < -11'sd512)
             || ($signed(norm_y) > 11'sd512) || ($signed(norm_y) < -11'sd512)
             || ($signed(norm_z) > 11'sd512) || ($signed(norm_z) < -11'sd512);

        have_code = 1'b1;
        code      = CODE_XNEG;
        if ($signed(norm_x) <= -11'sd256)
            code = CODE_XNEG;
        else if ($signed(norm_x) >= 11'sd256)
            code = CODE_XPOS;
        else if ($signed(norm_y) <= -11'sd256)
            code = CODE_YNEG;
        else if ($signed(norm_y) >= 11'sd256)
            code = CODE_YPOS;
        else if ($signed(norm_z) <= -11'sd256)
            code = CODE_ZNEG;
        else if ($signed(norm_z) >= 11'sd256)
            code = CODE_ZPOS;
        else
            have_code = 1'b0;

        tex_prod = {tex_u, 8'd0} - {8'd0, tex_u};
        texq     = tex_prod[23:16];

        res_next.err  = px.err || py.err || pz.err || n_err || !have_code
                     || (tex_u > 17'd65536);
        res_next.word = {texq, code, 5'd0, pz.neg, pz.mag, py.neg, py.mag, px.neg, px.mag};
        res_next.sp_x = px.sp;
        res_next.sp_y = py.sp;
        res_next.sp_z = pz.sp;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- design/vvpd_cell.sv -----
module vvpd_cell
#(
    parameter int unsigned DEPTH = vvpd_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned IDX   = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  vvpd_pkg::tok_t                tok_in,
    input  logic [$clog2(DEPTH)-1:0]      idx_in,
    output vvpd_pkg::tok_t                tok_out,
    output logic [$clog2(DEPTH)-1:0]      idx_out,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [vvpd_pkg::WORD_W-1:0]   wr_word
);
    import vvpd_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] word_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic              hit;

    always_comb
    begin
        hit      = tok_in.valid && !tok_in.found && (CW'(IDX) < count)
                && (word_reg == tok_in.key);
        tok_next = tok_in;
        idx_next = idx_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            idx_next       = IW'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == IW'(IDX)))
        begin
            word_reg <= wr_word;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule
